>>> hw/rtl/dmxtx_pkg.sv
// shared types and constants for the dmx512 packet transmitter
`default_nettype none
package dmxtx_pkg;

   localparam int SLOT_COUNT_DEF = 512;

   localparam int CMD_W      = 2;
   localparam int SLOT_IDX_W = 9;
   localparam int SLOT_VAL_W = 8;
   localparam int SLOT_CNT_W = 10;
   localparam int LEN_W      = 16;
   localparam int BIT_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int FRAME_W    = 11;
   localparam int BITPOS_W   = 4;
   localparam int EPOCH_W    = 4;

   localparam logic [LEN_W-1:0]    BREAK_LENGTH_RST = 16'd150;
   localparam logic [LEN_W-1:0]    MAB_LENGTH_RST   = 16'd15;
   localparam logic [BIT_W-1:0]    BIT_TICKS_RST    = 8'd4;
   localparam logic [BITPOS_W-1:0] FRAME_BITS       = 4'd11;
   localparam logic [FRAME_W-1:0]  FRAME_IDLE       = 11'h7ff;
   localparam logic [SLOT_VAL_W-1:0] START_CODE     = 8'h00;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_SEND  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BREAK_LENGTH = 2'd0,
      CSR_MAB_LENGTH   = 2'd1,
      CSR_BIT_TICKS    = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_BREAK = 4'b0010,
      PH_MAB   = 4'b0100,
      PH_FRAME = 4'b1000
   } phase_type;

   typedef struct packed {
      cmd_type                 command;
      logic [SLOT_IDX_W-1:0]   slot_index;
      logic [SLOT_VAL_W-1:0]   slot_value;
      logic [SLOT_CNT_W-1:0]   slot_count;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic status;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0] break_length;
      logic [LEN_W-1:0] mab_length;
      logic [BIT_W-1:0] bit_ticks;
   } cfg_type;

   typedef struct packed {
      logic                  wr_en;
      logic                  clr;
      logic [SLOT_IDX_W-1:0] idx;
      logic [SLOT_VAL_W-1:0] data;
   } store_cmd_type;

endpackage
`default_nettype wire

>>> hw/rtl/dmxtx_store.sv
// channel slot memory with clear epochs and a clearing sweep
`default_nettype none
module dmxtx_store #(
   parameter int SLOT_COUNT = dmxtx_pkg::SLOT_COUNT_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire dmxtx_pkg::store_cmd_type         st_cmd,
   input  wire logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] rd_idx,
   output logic [dmxtx_pkg::SLOT_VAL_W-1:0]      rd_data,
   output logic                                  sweep_busy
);
   import dmxtx_pkg::*;

   localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int WORD_W = EPOCH_W + SLOT_VAL_W;
   localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(SLOT_COUNT - 1);
   localparam logic [SLOT_IDX_W:0]   DEPTH_V   = (SLOT_IDX_W + 1)'(SLOT_COUNT);
   localparam logic [EPOCH_W-1:0]    EPOCH_MAX = '1;
   localparam logic [EPOCH_W-1:0]    EPOCH_ONE = EPOCH_W'(1);

   logic [WORD_W-1:0] mem [SLOT_COUNT];

   logic [WORD_W-1:0]  rd_word_ff;
   logic               sweep_ff, sweep_in;
   logic [ADDR_W-1:0]  sweep_idx_ff, sweep_idx_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_addr;
   logic [WORD_W-1:0]  mem_wdata;
   logic               in_range;

   assign in_range = {1'b0, st_cmd.idx} < DEPTH_V;

   // tag 0 marks a swept slot and is never a live epoch
   always_comb begin
      sweep_in     = sweep_ff;
      sweep_idx_in = sweep_idx_ff;
      epoch_in     = epoch_ff;
      mem_we       = 1'b0;
      mem_addr     = st_cmd.idx[ADDR_W-1:0];
      mem_wdata    = {epoch_ff, st_cmd.data};
      if (sweep_ff) begin
         mem_we    = 1'b1;
         mem_addr  = sweep_idx_ff;
         mem_wdata = '0;
         sweep_idx_in = sweep_idx_ff + ADDR_W'(1);
         if (sweep_idx_ff == LAST_ADDR) begin
            sweep_in = 1'b0;
         end
      end else if (st_cmd.clr) begin
         if (epoch_ff == EPOCH_MAX) begin
            sweep_in     = 1'b1;
            sweep_idx_in = '0;
            epoch_in     = EPOCH_ONE;
         end else begin
            epoch_in = epoch_ff + EPOCH_ONE;
         end
      end else if (st_cmd.wr_en && in_range) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= 1'b1;
         sweep_idx_ff <= '0;
         epoch_ff     <= EPOCH_ONE;
      end else begin
         sweep_ff     <= sweep_in;
         sweep_idx_ff <= sweep_idx_in;
         epoch_ff     <= epoch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_word_ff <= mem[rd_idx];
   end

   assign rd_data = (rd_word_ff[WORD_W-1 -: EPOCH_W] == epoch_ff)
                    ? rd_word_ff[SLOT_VAL_W-1:0] : '0;
   assign sweep_busy = sweep_ff;

endmodule
`default_nettype wire

>>> hw/rtl/dmxtx_seq.sv
// packet sequencer: break, mark after break and serial frames
`default_nettype none
module dmxtx_seq #(
   parameter int SLOT_COUNT = dmxtx_pkg::SLOT_COUNT_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_fire,
   input  wire dmxtx_pkg::req_type               req_item,
   input  wire dmxtx_pkg::cfg_type               cfg,
   input  wire logic [dmxtx_pkg::SLOT_VAL_W-1:0] slot_data,
   output dmxtx_pkg::rsp_type                    rsp_item,
   output dmxtx_pkg::store_cmd_type              st_cmd,
   output logic [(SLOT_COUNT > 1 ? $clog2(SLOT_COUNT) : 1)-1:0] rd_idx
);
   import dmxtx_pkg::*;

   localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam logic [SLOT_CNT_W-1:0] MAX_REQ = SLOT_CNT_W'(SLOT_COUNT);
   localparam logic [CNT_W-1:0]      MAX_CNT = CNT_W'(SLOT_COUNT);

   phase_type              phase_ff, phase_in;
   logic [LEN_W-1:0]       tick_ff, tick_in;
   logic [BITPOS_W-1:0]    bitpos_ff, bitpos_in;
   logic [FRAME_W-1:0]     shift_ff, shift_in;
   logic [CNT_W-1:0]       sent_ff, sent_in;
   logic [CNT_W-1:0]       total_ff, total_in;

   logic [LEN_W-1:0]       tick_inc;
   logic [BITPOS_W-1:0]    bit_inc;
   logic                   status;
   logic [15:0]            shift_wide;

   assign tick_inc = tick_ff + LEN_W'(1);
   assign bit_inc  = bitpos_ff + BITPOS_W'(1);

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bitpos_in = bitpos_ff;
      shift_in  = shift_ff;
      sent_in   = sent_ff;
      total_in  = total_ff;
      status    = 1'b0;
      st_cmd.wr_en = 1'b0;
      st_cmd.clr   = 1'b0;
      st_cmd.idx   = req_item.slot_index;
      st_cmd.data  = req_item.slot_value;
      if (req_fire) begin
         if (req_item.command == CMD_TICK) begin
            case (phase_ff)
               PH_BREAK: begin
                  tick_in = tick_inc;
                  if (tick_inc >= cfg.break_length) begin
                     phase_in = PH_MAB;
                     tick_in  = '0;
                  end
               end
               PH_MAB: begin
                  tick_in = tick_inc;
                  if (tick_inc >= cfg.mab_length) begin
                     phase_in  = PH_FRAME;
                     shift_in  = {2'b11, START_CODE, 1'b0};
                     bitpos_in = '0;
                     tick_in   = '0;
                  end
               end
               PH_FRAME: begin
                  tick_in = tick_inc;
                  if (tick_inc >= {{(LEN_W-BIT_W){1'b0}}, cfg.bit_ticks}) begin
                     tick_in   = '0;
                     bitpos_in = bit_inc;
                     if (bit_inc >= FRAME_BITS) begin
                        if (sent_ff < total_ff) begin
                           // next slot was prefetched while this frame went out
                           shift_in  = {2'b11, slot_data, 1'b0};
                           bitpos_in = '0;
                           sent_in   = sent_ff + CNT_W'(1);
                        end else begin
                           phase_in  = PH_IDLE;
                           bitpos_in = '0;
                           shift_in  = FRAME_IDLE;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end else if (phase_ff != PH_IDLE) begin
            status = 1'b1;
         end else begin
            case (req_item.command)
               CMD_WRITE: st_cmd.wr_en = 1'b1;
               CMD_CLEAR: st_cmd.clr   = 1'b1;
               CMD_SEND: begin
                  if (req_item.slot_count == '0 || req_item.slot_count > MAX_REQ) begin
                     total_in = MAX_CNT;
                  end else begin
                     total_in = CNT_W'(req_item.slot_count);
                  end
                  sent_in   = '0;
                  phase_in  = PH_BREAK;
                  tick_in   = '0;
                  bitpos_in = '0;
                  shift_in  = FRAME_IDLE;
               end
               default: ;
            endcase
         end
      end
   end

   assign shift_wide = {{(16-FRAME_W){1'b0}}, shift_in};

   always_comb begin
      case (phase_in)
         PH_BREAK: rsp_item.line_level = 1'b0;
         PH_FRAME: rsp_item.line_level = shift_wide[bitpos_in];
         default:  rsp_item.line_level = 1'b1;
      endcase
      rsp_item.busy_res = (phase_in != PH_IDLE);
      rsp_item.status   = status;
   end

   assign rd_idx = sent_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         tick_ff   <= '0;
         bitpos_ff <= '0;
         shift_ff  <= FRAME_IDLE;
         sent_ff   <= '0;
         total_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         bitpos_ff <= bitpos_in;
         shift_ff  <= shift_in;
         sent_ff   <= sent_in;
         total_ff  <= total_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/dmxtx_outq.sv
// two-entry result buffer between the sequencer and the rsp port
`default_nettype none
module dmxtx_outq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire dmxtx_pkg::rsp_type push_data,
   output logic                    push_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output dmxtx_pkg::rsp_type      rsp_data
);
   import dmxtx_pkg::*;

   logic    head_vld_ff, head_vld_in;
   logic    skid_vld_ff, skid_vld_in;
   rsp_type head_ff, head_in;
   rsp_type skid_ff, skid_in;
   logic    pop;

   assign pop        = head_vld_ff && rsp_ready;
   assign push_ready = !skid_vld_ff;

   always_comb begin
      head_vld_in = head_vld_ff;
      skid_vld_in = skid_vld_ff;
      head_in     = head_ff;
      skid_in     = skid_ff;
      if (pop) begin
         // a push during a pop only happens with the skid word empty
         if (push) begin
            head_in = push_data;
         end else begin
            head_in     = skid_ff;
            head_vld_in = skid_vld_ff;
            skid_vld_in = 1'b0;
         end
      end else if (push) begin
         if (!head_vld_ff) begin
            head_in     = push_data;
            head_vld_in = 1'b1;
         end else begin
            skid_in     = push_data;
            skid_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         head_vld_ff <= head_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = head_vld_ff;
   assign rsp_data  = head_ff;

endmodule
`default_nettype wire

>>> hw/rtl/dmx512_packet_transmitter.sv
// results buffer two deep: a word's result is registered into it when accepted
// throughput: one word per cycle, ticks included, while req_ready is high
// the slot memory read is registered and runs ahead of each frame load
// reset: synchronous; then a clearing sweep over every slot with req_ready low
// every fifteenth clear command wraps the clear epoch and runs the same sweep
// configuration registers reset to 150, 15 and 4
`default_nettype none
module dmx512_packet_transmitter #(
   parameter int SLOT_COUNT = dmxtx_pkg::SLOT_COUNT_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire dmxtx_pkg::req_type               req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output dmxtx_pkg::rsp_type                    rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [dmxtx_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dmxtx_pkg::CSR_DATA_W-1:0] csr_data
);
   import dmxtx_pkg::*;

   localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   cfg_type       cfg_ff, cfg_in;
   store_cmd_type st_cmd;
   rsp_type       seq_rsp;
   logic [ADDR_W-1:0]     rd_idx;
   logic [SLOT_VAL_W-1:0] slot_data;
   logic                  sweep_busy;
   logic                  q_ready;
   logic                  req_fire;

   assign csr_ready = 1'b1;
   assign req_ready = q_ready && !sweep_busy;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BREAK_LENGTH: cfg_in.break_length = csr_data;
            CSR_MAB_LENGTH:   cfg_in.mab_length   = csr_data;
            CSR_BIT_TICKS:    cfg_in.bit_ticks    = csr_data[BIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.break_length <= BREAK_LENGTH_RST;
         cfg_ff.mab_length   <= MAB_LENGTH_RST;
         cfg_ff.bit_ticks    <= BIT_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dmxtx_store #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .st_cmd     (st_cmd),
      .rd_idx     (rd_idx),
      .rd_data    (slot_data),
      .sweep_busy (sweep_busy)
   );

   dmxtx_seq #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_item  (req_data),
      .cfg       (cfg_ff),
      .slot_data (slot_data),
      .rsp_item  (seq_rsp),
      .st_cmd    (st_cmd),
      .rd_idx    (rd_idx)
   );

   dmxtx_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (req_fire),
      .push_data  (seq_rsp),
      .push_ready (q_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
